/* rtl/core/sha256_pkg.sv */
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		BYTE_IN,
		BYTE_MARK,
		BYTE_ZERO,
		BYTE_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      count_en;
		logic      load_vars;
		logic      round_en;
		logic      update_en;
		logic      finish;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_56;
		logic round_last;
		logic obuf_busy;
	} dp_stat_t;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] INIT_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

/* rtl/core/sha256_ctrl.sv */
module sha256_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	input  logic                s_tuser,
	output logic                s_tready,
	input  sha256_pkg::dp_stat_t stat,
	output sha256_pkg::dp_cmd_t  cmd
);

	sha256_pkg::state_t state_q, state_nxt;
	logic pad_q, first_q, len_q;
	logic acc, blk_full;

	assign acc      = (state_q == sha256_pkg::ST_IDLE) && s_tvalid;
	assign blk_full = acc && s_tuser && stat.pos_last;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (blk_full)
					state_nxt = sha256_pkg::ST_ROUND;
				else if (acc && s_tlast)
					state_nxt = sha256_pkg::ST_PAD;
			end
			sha256_pkg::ST_ROUND: begin
				if (stat.round_last)
					state_nxt = sha256_pkg::ST_UPDATE;
			end
			sha256_pkg::ST_UPDATE: begin
				if (len_q)
					state_nxt = sha256_pkg::ST_DONE;
				else if (pad_q)
					state_nxt = sha256_pkg::ST_PAD;
				else
					state_nxt = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_PAD: begin
				if (stat.pos_last)
					state_nxt = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_DONE: begin
				if (!stat.obuf_busy)
					state_nxt = sha256_pkg::ST_IDLE;
			end
			default: state_nxt = sha256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		cmd.byte_sel = sha256_pkg::BYTE_IN;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.shift_en  = acc && s_tuser;
				cmd.count_en  = acc && s_tuser;
				cmd.load_vars = blk_full;
			end
			sha256_pkg::ST_ROUND: begin
				cmd.round_en = 1'b1;
			end
			sha256_pkg::ST_UPDATE: begin
				cmd.update_en = 1'b1;
			end
			sha256_pkg::ST_PAD: begin
				cmd.shift_en  = 1'b1;
				cmd.load_vars = stat.pos_last;
				if (first_q)
					cmd.byte_sel = sha256_pkg::BYTE_MARK;
				else if (len_q || stat.pos_56)
					cmd.byte_sel = sha256_pkg::BYTE_LEN;
				else
					cmd.byte_sel = sha256_pkg::BYTE_ZERO;
			end
			sha256_pkg::ST_DONE: begin
				cmd.finish = !stat.obuf_busy;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && s_tlast) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
				len_q   <= 1'b0;
			end
			if (state_q == sha256_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (!first_q && stat.pos_56)
					len_q <= 1'b1;
			end
			if (cmd.finish) begin
				pad_q <= 1'b0;
				len_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/sha256_dp.sv */
module sha256_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           s_tdata,
	input  sha256_pkg::dp_cmd_t  cmd,
	output sha256_pkg::dp_stat_t stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,
	output logic                 m_tlast
);

	logic [511:0] win_q;
	logic [31:0]  vars_q [0:7];
	logic [31:0]  hash_q [0:7];
	logic [31:0]  obuf_q [0:7];
	logic [63:0]  count_q;
	logic [5:0]   pos_q;
	logic [5:0]   round_q;
	logic         ovalid_q;
	logic [2:0]   oidx_q;

	logic [7:0]   byte_nxt;
	logic [63:0]  len_bits;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  t1, t2, ch, maj;
	logic         out_take;

	assign len_bits = {count_q[60:0], 3'b000};

	always_comb begin
		unique case (cmd.byte_sel)
			sha256_pkg::BYTE_IN:   byte_nxt = s_tdata;
			sha256_pkg::BYTE_MARK: byte_nxt = sha256_pkg::PAD_MARK;
			sha256_pkg::BYTE_ZERO: byte_nxt = 8'h00;
			sha256_pkg::BYTE_LEN:  byte_nxt = 8'(len_bits >> {~pos_q[2:0], 3'b000});
			default:               byte_nxt = 8'h00;
		endcase
	end

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_new = sha256_pkg::ssig1(w14) + w9 + sha256_pkg::ssig0(w1) + w0;

	assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
	assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
	assign t1  = vars_q[7] + sha256_pkg::bsig1(vars_q[4]) + ch
		+ sha256_pkg::ROUND_K[round_q] + w0;
	assign t2  = sha256_pkg::bsig0(vars_q[0]) + maj;

	assign stat.pos_last   = (pos_q == 6'd63);
	assign stat.pos_56     = (pos_q == 6'd56);
	assign stat.round_last = (round_q == 6'd63);
	assign stat.obuf_busy  = ovalid_q;

	assign out_take = ovalid_q && m_tready;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {5'b0, oidx_q, obuf_q[0]};
	assign m_tlast  = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (cmd.shift_en)
			win_q <= {win_q[503:0], byte_nxt};
		else if (cmd.round_en)
			win_q <= {win_q[479:0], w_new};
		if (cmd.load_vars) begin
			for (int i = 0; i < 8; i++)
				vars_q[i] <= hash_q[i];
		end else if (cmd.round_en) begin
			vars_q[0] <= t1 + t2;
			vars_q[1] <= vars_q[0];
			vars_q[2] <= vars_q[1];
			vars_q[3] <= vars_q[2];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[5] <= vars_q[4];
			vars_q[6] <= vars_q[5];
			vars_q[7] <= vars_q[6];
		end
		if (cmd.finish) begin
			for (int i = 0; i < 8; i++)
				obuf_q[i] <= hash_q[i];
		end else if (out_take) begin
			for (int i = 0; i < 7; i++)
				obuf_q[i] <= obuf_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_q[i] <= sha256_pkg::INIT_HASH[i];
			count_q  <= '0;
			pos_q    <= '0;
			round_q  <= '0;
			ovalid_q <= 1'b0;
			oidx_q   <= '0;
		end else begin
			if (cmd.shift_en)
				pos_q <= pos_q + 6'd1;
			if (cmd.count_en)
				count_q <= count_q + 64'd1;
			if (cmd.round_en)
				round_q <= round_q + 6'd1;
			if (cmd.update_en) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + vars_q[i];
			end
			if (cmd.finish) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= sha256_pkg::INIT_HASH[i];
				count_q  <= '0;
				pos_q    <= '0;
				ovalid_q <= 1'b1;
				oidx_q   <= '0;
			end else if (out_take) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7)
					ovalid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/sha256_stream_hasher.sv */
// channel | direction | tdata                                      | tuser        | tlast
// s_      | in        | [7:0] data_byte                            | byte_present | end_of_message
// m_      | out       | [31:0] digest_word, [34:32] word_index     | -            | last_word
//
// One message byte per cycle while no block, padding or digest hand-off is in work.
// A full 64-byte block stalls input through its rounds and the hash update.
// Message end adds the pad bytes (9 to 72 bytes), shifted in one at a time, and their compressions.
// Digest leaves through an 8-word output buffer; input resumes once it is loaded.
// The message window serves byte shifts and the single one-round unit, so no byte is taken while a block compresses.
// After reset: initial hash loaded, byte count zero, block ready for input.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast
);

	sha256_pkg::dp_cmd_t  cmd;
	sha256_pkg::dp_stat_t stat;

	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha256_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |-> !s_tready)
		else $error("request taken during compression");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !m_tvalid)
		else $error("digest overwrites pending output");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output still valid after last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_en |-> !cmd.round_en)
		else $error("byte shift during round");

endmodule
